@@ hw/rtl/ugq_pkg.sv @@
`default_nettype none
package ugq_pkg;

  // field widths
  localparam int unsigned SampleW = 32;
  localparam int unsigned NumW    = 9;
  localparam int unsigned CodeW   = 8;

  // landmark count saturates here
  localparam logic [NumW-1:0] MaxLandmarks = 9'd256;

  // request kinds carried in tuser[0]
  localparam logic ReqMeasure  = 1'b0;
  localparam logic ReqQuantize = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StScan = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  // handshake between sequencer and a worker unit
  typedef struct packed {
    logic start;
  } ugq_cmd_t;

  typedef struct packed {
    logic done;
  } ugq_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/uniform_grid_quantizer_top.sv @@
`default_nettype none
// Channel  | Dir | Payload                                   | Handshake
// s_axis   | in  | tdata: sample; tuser: req_type, first     | tvalid/tready
// m_axis   | out | tdata: code, range_min, range_max         | tvalid/tready
// cfg      | in  | cfg_wdata_i: num_landmarks                | cfg_we_i
//
// Measure request: taken while idle, no result.
// Quantize request: after it is taken, the divide, the scan load, the landmark scan
// (up to n landmarks, until the distance grows), the scan exit and the output load
// follow in order, n = landmark count.
// Ready is low until the result loads; a stalled result holds while measures proceed.
// Reset: range reads empty (min most positive, max most negative), 16 landmarks.
module uniform_grid_quantizer_top import ugq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [NumW-1:0]    cfg_wdata_i,   // num_landmarks
  // request stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [SampleW-1:0] s_axis_tdata,  // [31:0] sample
  input  wire logic [1:0]         s_axis_tuser,  // [0] req_type, [1] first_of_pass
  // result stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [71:0]             m_axis_tdata   // [7:0] code, [39:8] min, [71:40] max
);

  state_e              state_q, state_d;
  logic [NumW-1:0]     cfg_q;
  logic [SampleW-1:0]  min_q, min_d;
  logic [SampleW-1:0]  max_q, max_d;
  logic [SampleW-1:0]  x_q;
  logic [NumW-1:0]     n_q;
  logic                m_valid_q, m_valid_d;
  logic [71:0]         m_data_q;

  logic                accept;
  logic                is_quant;
  logic [NumW-1:0]     n_eff;
  logic [SampleW:0]    span;
  logic [SampleW-1:0]  delta;
  logic                load_out;
  ugq_cmd_t            div_cmd, scan_cmd;
  ugq_stat_t           div_stat, scan_stat;
  logic [SampleW-1:0]  quotient;
  logic [CodeW-1:0]    code;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_quant      = (s_axis_tuser[0] == ReqQuantize);

  // effective landmark count
  always_comb begin
    if (cfg_q == '0) begin
      n_eff = NumW'(1);
    end else if (cfg_q > MaxLandmarks) begin
      n_eff = MaxLandmarks;
    end else begin
      n_eff = cfg_q;
    end
  end

  // range width, empty range counts as zero
  always_comb begin
    span  = {max_q[SampleW-1], max_q} - {min_q[SampleW-1], min_q};
    delta = span[SampleW] ? '0 : span[SampleW-1:0];
  end

  // running min and max
  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (accept && (s_axis_tuser[0] == ReqMeasure)) begin
      if (s_axis_tuser[1]) begin
        min_d = s_axis_tdata;
        max_d = s_axis_tdata;
      end else begin
        if ($signed(s_axis_tdata) < $signed(min_q)) min_d = s_axis_tdata;
        if ($signed(s_axis_tdata) > $signed(max_q)) max_d = s_axis_tdata;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    load_out  = 1'b0;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept && is_quant) state_d = StDiv;
      end
      StDiv: begin
        if (div_stat.done) state_d = StScan;
      end
      StScan: begin
        if (scan_stat.done) state_d = StOut;
      end
      StOut: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out  = 1'b1;
          m_valid_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign div_cmd.start  = accept && is_quant;
  assign scan_cmd.start = div_stat.done;

  // divider loads the range and count at the accepting edge
  ugq_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .dividend_i (delta),
    .divisor_i  (n_eff),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  ugq_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (scan_cmd),
    .sample_i (x_q),
    .base_i   (min_q),
    .step_i   (quotient),
    .num_i    (n_q),
    .stat_o   (scan_stat),
    .code_o   (code)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cfg_q     <= NumW'(16);
      min_q     <= {1'b0, {(SampleW-1){1'b1}}};
      max_q     <= {1'b1, {(SampleW-1){1'b0}}};
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      min_q     <= min_d;
      max_q     <= max_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
    end
  end

  // request capture and result register
  always_ff @(posedge clk_i) begin
    if (accept && is_quant) begin
      x_q <= s_axis_tdata;
      n_q <= n_eff;
    end
    if (load_out) begin
      m_data_q <= {max_q, min_q, code};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // checks
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == StDiv))
    else $error("divider finished outside divide state");

  a_scan_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_stat.done |-> (state_q == StScan))
    else $error("scan finished outside scan state");

  a_quant_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_quant) |=> (state_q == StDiv))
    else $error("quantize request did not start the divider");

  a_code_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> ({1'b0, code} < n_q))
    else $error("code beyond landmark count");

endmodule
`default_nettype wire

@@ hw/rtl/ugq_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module ugq_div import ugq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ugq_cmd_t           cmd_i,
  input  wire logic [SampleW-1:0] dividend_i,
  input  wire logic [NumW-1:0]    divisor_i,
  output ugq_stat_t               stat_o,
  output logic [SampleW-1:0]      quotient_o
);

  localparam int unsigned CntW = $clog2(SampleW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [NumW-1:0]     rem_q, rem_d;
  logic [NumW-1:0]     dvs_q, dvs_d;
  logic [SampleW-1:0]  quo_q, quo_d;

  logic [NumW:0]       trial;
  logic                ge;
  logic [NumW:0]       diff;

  // one shift-subtract step
  always_comb begin
    trial  = {rem_q, quo_q[SampleW-1]};
    ge     = (trial >= {1'b0, dvs_q});
    diff   = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[NumW-1:0] : trial[NumW-1:0];
      quo_d = {quo_q[SampleW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(SampleW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule
`default_nettype wire

@@ hw/rtl/ugq_scan.sv @@
`default_nettype none
// Landmark scan: one landmark per cycle, one add for the mark and one
// subtract and compare for the distance. The distance along the grid is
// convex, so the scan stops once it starts to grow or at the last landmark.
module ugq_scan import ugq_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ugq_cmd_t           cmd_i,
  input  wire logic [SampleW-1:0] sample_i,
  input  wire logic [SampleW-1:0] base_i,
  input  wire logic [SampleW-1:0] step_i,
  input  wire logic [NumW-1:0]    num_i,
  output ugq_stat_t               stat_o,
  output logic [CodeW-1:0]        code_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CodeW-1:0]    idx_q, idx_d;
  logic [CodeW-1:0]    best_idx_q, best_idx_d;
  logic [SampleW:0]    best_q, best_d;
  logic [SampleW:0]    mark_q, mark_d;
  logic [SampleW-1:0]  x_q, x_d;
  logic [SampleW-1:0]  step_q, step_d;
  logic [NumW-1:0]     last_q, last_d;

  logic [SampleW+1:0]  sdiff;
  logic [SampleW+1:0]  mag;
  logic [SampleW:0]    cur_dist;
  logic                take;
  logic                stop;

  // distance of the sample to the current mark
  always_comb begin
    sdiff    = {{2{x_q[SampleW-1]}}, x_q} - {mark_q[SampleW], mark_q};
    mag      = sdiff[SampleW+1] ? (~sdiff + 1'b1) : sdiff;
    cur_dist = mag[SampleW:0];
    take     = (idx_q == '0) || (cur_dist < best_q);
    stop     = ({1'b0, idx_q} == last_q) || ((idx_q != '0) && (cur_dist > best_q));
  end

  // scan sequencing
  always_comb begin
    busy_d     = busy_q;
    done_d     = 1'b0;
    idx_d      = idx_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    mark_d     = mark_q;
    x_d        = x_q;
    step_d     = step_q;
    last_d     = last_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
      mark_d = {base_i[SampleW-1], base_i};
      x_d    = sample_i;
      step_d = step_i;
      last_d = num_i - 1'b1;
    end else if (busy_q) begin
      if (take) begin
        best_d     = cur_dist;
        best_idx_d = idx_q;
      end
      idx_d  = idx_q + 1'b1;
      mark_d = mark_q + {1'b0, step_q};
      if (stop) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    mark_q     <= mark_d;
    x_q        <= x_d;
    step_q     <= step_d;
    last_q     <= last_d;
  end

  assign stat_o.done = done_q;
  assign code_o      = best_idx_q;

endmodule
`default_nettype wire
